>>> hw/rtl/v3n_pkg.sv
package v3n_pkg;

	// Coordinate width (signed Q16.16 at 32 bits)
	localparam int COORD_WIDTH = 32;
	localparam int IN_BYTES    = (3 * COORD_WIDTH + 7) / 8;
	localparam int IN_W        = 8 * IN_BYTES;

	// Result format: signed Q2.30
	localparam int FRAC_BITS = 30;
	localparam int UNIT_W    = FRAC_BITS + 2;
	localparam int OUT_W     = 3 * UNIT_W;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NUM_CELLS = FRAC_BITS + 1;

	// Square of one magnitude, and the sum of three squares (3 * 2^(2W-2) < 2^(2W))
	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int SUM_W = 2 * COORD_WIDTH;

	// Remainder and step terms of the digit recurrence
	localparam int ACC_W   = 2 * COORD_WIDTH + 64;
	localparam int SHIFT_A = FRAC_BITS + 2;
	localparam int SHIFT_B = 2 * FRAC_BITS + 2;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		acc_t               rem;
		acc_t               step;
		logic [QUO_W-1:0]   quo;
		logic               neg;
	} lane_t;

	typedef struct packed {
		lane_t [2:0] lane;
		acc_t        sq_term;
		logic        zero;
	} word_t;

endpackage

>>> hw/rtl/v3n_cell.sv
module v3n_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  v3n_pkg::word_t in_word,
	output logic           out_vld,
	output v3n_pkg::word_t out_word
);
	import v3n_pkg::*;

	logic   vld_q;
	word_t  word_q;
	word_t  word_d;
	acc_t   diff  [3];
	logic   take  [3];

	// Try the next quotient bit in each lane; keep it when the remainder stays non-negative
	always_comb begin
		word_d = in_word;
		word_d.sq_term = in_word.sq_term >>> 2;
		for (int i = 0; i < 3; i++) begin
			diff[i] = in_word.lane[i].rem - (in_word.lane[i].step + in_word.sq_term);
			take[i] = ~diff[i][ACC_W-1];
			word_d.lane[i].quo = {in_word.lane[i].quo[QUO_W-2:0], take[i]};
			if (take[i]) begin
				word_d.lane[i].rem  = diff[i];
				word_d.lane[i].step = (in_word.lane[i].step >>> 1) + in_word.sq_term;
			end else begin
				word_d.lane[i].step = in_word.lane[i].step >>> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_d;
		end
	end

	assign out_vld  = vld_q;
	assign out_word = word_q;

endmodule

>>> hw/rtl/vector3_normalize.sv
// Pipeline: four front stages, one cell per result bit and one output register lie between
// an accepted input word and its output word.
// Throughput: one vector per cycle; the whole pipe advances together and holds only
// while the output word waits to be taken.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module vector3_normalize (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// x_coord, y_coord, z_coord from bit 0 up, zero filled to whole bytes
	input  logic [v3n_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// unit_x, unit_y, unit_z from bit 0 up
	output logic [v3n_pkg::OUT_W-1:0]   m_axis_tdata,
	// zero_length
	output logic                        m_axis_tuser
);
	import v3n_pkg::*;

	// Whole pipe moves when the output register is free or being drained
	logic ce;

	// Stage 1: split each coordinate into sign and magnitude
	logic                   vld_s1;
	logic [COORD_WIDTH-1:0] mag_s1 [3];
	logic [2:0]             neg_s1;
	logic                   zero_s1;

	// Stage 2: squares of the magnitudes
	logic                   vld_s2;
	logic [SQ_W-1:0]        sq_s2  [3];
	logic [2:0]             neg_s2;
	logic                   zero_s2;

	// Stage 3: sum of squares
	logic                   vld_s3;
	logic [SQ_W-1:0]        sq_s3  [3];
	logic [SUM_W-1:0]       sum_s3;
	logic [2:0]             neg_s3;
	logic                   zero_s3;

	// Stage 4 feeds the cell row; chain index k is the input of cell k
	logic                   chain_vld  [NUM_CELLS+1];
	word_t                  chain_word [NUM_CELLS+1];
	logic                   vld_s4;
	word_t                  word_s4;
	word_t                  init_word;
	acc_t                   sum_ext;

	// Output register
	logic                   out_vld_q;
	logic [OUT_W-1:0]       out_data_q;
	logic                   out_zero_q;
	logic [OUT_W-1:0]       out_data_d;
	logic [UNIT_W-1:0]      quo_ext [3];

	assign ce            = ~out_vld_q | m_axis_tready;
	assign s_axis_tready = ce;

	// Valid chain of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Front data path: magnitude, square, sum
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= s_axis_tdata[i*COORD_WIDTH + COORD_WIDTH - 1];
				mag_s1[i] <= s_axis_tdata[i*COORD_WIDTH + COORD_WIDTH - 1]
					? (~s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH] + COORD_WIDTH'(1))
					: s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
				sq_s2[i]  <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);
				sq_s3[i]  <= sq_s2[i];
			end
			zero_s1 <= (s_axis_tdata[3*COORD_WIDTH-1:0] == '0);
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			word_s4 <= init_word;
		end
	end

	// Start the recurrence with the trial root u = -1:
	// rem = c^2 * 2^62 - S, step = u * S * 2^32, sq_term = S * 2^62
	always_comb begin
		sum_ext = acc_t'({{(ACC_W-SUM_W){1'b0}}, sum_s3});
		init_word.sq_term = sum_ext <<< SHIFT_B;
		init_word.zero    = zero_s3;
		for (int i = 0; i < 3; i++) begin
			init_word.lane[i].rem  = (acc_t'({{(ACC_W-SQ_W){1'b0}}, sq_s3[i]}) <<< SHIFT_B)
				- sum_ext;
			init_word.lane[i].step = -(sum_ext <<< SHIFT_A);
			init_word.lane[i].quo  = '0;
			init_word.lane[i].neg  = neg_s3[i];
		end
	end

	assign chain_vld[0]  = vld_s4;
	assign chain_word[0] = word_s4;

	// One cell per result bit, most significant first
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		v3n_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (ce),
			.in_vld   (chain_vld[k]),
			.in_word  (chain_word[k]),
			.out_vld  (chain_vld[k+1]),
			.out_word (chain_word[k+1])
		);
	end

	// Apply signs; drop everything for a zero vector
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo_ext[i] = {1'b0, chain_word[NUM_CELLS].lane[i].quo};
			if (chain_word[NUM_CELLS].zero) begin
				out_data_d[i*UNIT_W +: UNIT_W] = '0;
			end else if (chain_word[NUM_CELLS].lane[i].neg) begin
				out_data_d[i*UNIT_W +: UNIT_W] = -quo_ext[i];
			end else begin
				out_data_d[i*UNIT_W +: UNIT_W] = quo_ext[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ce) begin
			out_vld_q <= chain_vld[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_data_q <= out_data_d;
			out_zero_q <= chain_word[NUM_CELLS].zero;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_zero_q;

	// A zero vector yields all-zero components
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("zero vector gave nonzero components");

	// No component exceeds 1.0 in magnitude
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			($signed(m_axis_tdata[UNIT_W-1:0]) <= $signed(UNIT_W'(1) << FRAC_BITS)
			&& $signed(m_axis_tdata[UNIT_W-1:0]) >= -$signed(UNIT_W'(1) << FRAC_BITS)
			&& $signed(m_axis_tdata[2*UNIT_W-1:UNIT_W]) <= $signed(UNIT_W'(1) << FRAC_BITS)
			&& $signed(m_axis_tdata[2*UNIT_W-1:UNIT_W]) >= -$signed(UNIT_W'(1) << FRAC_BITS)
			&& $signed(m_axis_tdata[3*UNIT_W-1:2*UNIT_W]) <= $signed(UNIT_W'(1) << FRAC_BITS)
			&& $signed(m_axis_tdata[3*UNIT_W-1:2*UNIT_W]) >= -$signed(UNIT_W'(1) << FRAC_BITS)))
		else $error("unit component out of range");

	// A stalled output word must not let the last cell move on
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(chain_vld[NUM_CELLS]))
		else $error("cell row advanced during output stall");

	// The input side takes words exactly when the pipe advances
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready decoupled from pipe advance");

endmodule

>>> sim/vector3_normalize_test.sv
`timescale 1ns / 100ps

module vector3_normalize_test;
	import v3n_pkg::*;

	// One normalized result: three Q2.30 components and the zero-length flag
	typedef struct packed {
		logic [31:0] unit_x;
		logic [31:0] unit_y;
		logic [31:0] unit_z;
		logic        zero_length;
	} unit_vec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	// x_coord, y_coord, z_coord from bit 0 up
	logic [IN_W-1:0]    s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	// unit_x, unit_y, unit_z from bit 0 up
	logic [OUT_W-1:0]   m_axis_tdata;
	// zero_length
	logic               m_axis_tuser;

	unit_vec_t          pending_units[$];
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 cycle_count = 0;
	bit                 failed = 1'b0;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	vector3_normalize uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL vector3_normalize");
			$finish;
		end
	end

	// Receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Rounded magnitude of mag * 2^30 / sqrt(sum): the largest q whose
	// lower rounding boundary (2q-1)^2 * sum stays within mag^2 * 2^62.
	function automatic logic [31:0] unit_magnitude(logic [31:0] mag, logic [191:0] sum);
		logic [191:0] bound;
		logic [191:0] lhs;
		logic [191:0] odd;
		logic [31:0]  q;
		logic [31:0]  t;
		bound = ({160'd0, mag} * {160'd0, mag}) << 62;
		q = '0;
		for (int b = 30; b >= 0; b--) begin
			t = q | (32'd1 << b);
			odd = 2 * {160'd0, t} - 1;
			lhs = odd * odd * sum;
			if (lhs <= bound)
				q = t;
		end
		return q;
	endfunction

	function automatic unit_vec_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		logic [31:0]  coord[3];
		logic [31:0]  mag[3];
		logic [31:0]  comp[3];
		logic [191:0] sum;
		unit_vec_t    r;
		coord[0] = x;
		coord[1] = y;
		coord[2] = z;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			// most negative value keeps its full magnitude 2^31 as unsigned
			mag[i] = coord[i][31] ? -coord[i] : coord[i];
			sum += {160'd0, mag[i]} * {160'd0, mag[i]};
		end
		if (sum == 0) begin
			r = '0;
			r.zero_length = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			comp[i] = unit_magnitude(mag[i], sum);
			if (coord[i][31])
				comp[i] = -comp[i];
		end
		r.unit_x = comp[0];
		r.unit_y = comp[1];
		r.unit_z = comp[2];
		r.zero_length = 1'b0;
		return r;
	endfunction

	// Present one vector, holding it until taken; call and return at a rising edge
	task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		bit ready;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x};
		do begin
			@(negedge clk);
			ready = s_axis_tready;
			@(posedge clk);
		end while (!ready);
		pending_units.push_back(normalize(x, y, z));
	endtask

	// Drop valid and wait until every expected word has come out
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Compare each word taken from the output with the oldest expectation
	always @(negedge clk) begin
		unit_vec_t want;
		unit_vec_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
				m_axis_tuser};
			if (pending_units.size() == 0) begin
				$display("%0t: unexpected output word %h", $time, got);
				failed = 1'b1;
			end else begin
				want = pending_units.pop_front();
				if (got.unit_x !== want.unit_x) begin
					$display("%0t: unit_x expected %h actual %h", $time, want.unit_x,
						got.unit_x);
					failed = 1'b1;
				end
				if (got.unit_y !== want.unit_y) begin
					$display("%0t: unit_y expected %h actual %h", $time, want.unit_y,
						got.unit_y);
					failed = 1'b1;
				end
				if (got.unit_z !== want.unit_z) begin
					$display("%0t: unit_z expected %h actual %h", $time, want.unit_z,
						got.unit_z);
					failed = 1'b1;
				end
				if (got.zero_length !== want.zero_length) begin
					$display("%0t: zero_length expected %b actual %b", $time,
						want.zero_length, got.zero_length);
					failed = 1'b1;
				end
			end
		end
	end

	// Zero vector, axis-aligned vectors, extremes and lopsided magnitudes
	task automatic test_corner_vectors;
		send_vector(32'h0, 32'h0, 32'h0);
		send_vector(32'h1, 32'h0, 32'h0);
		send_vector(32'h0, 32'hFFFF_FFFF, 32'h0);
		send_vector(32'h0, 32'h0, 32'h0001_0000);
		send_vector(32'h7FFF_FFFF, 32'h0, 32'h0);
		send_vector(32'h8000_0000, 32'h0, 32'h0);
		send_vector(32'h0, 32'h8000_0000, 32'h0);
		send_vector(32'h0, 32'h0, 32'h8000_0000);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_vector(32'h1, 32'h1, 32'h1);
		send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_vector(32'd3, 32'd4, 32'h0);
		send_vector(32'h7FFF_FFFF, 32'h1, 32'h0);
		send_vector(32'h8000_0000, 32'hFFFF_FFFF, 32'h1);
		send_vector(32'h0, 32'h0, 32'h0);
		send_vector(32'h0003_0000, 32'hFFFC_0000, 32'h000C_0000);
		send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
		// hold off until the pipe is empty, then restart
		drain();
	endtask

	task automatic test_random_vectors(int count);
		logic [31:0] c[3];
		int          kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(9);
			for (int i = 0; i < 3; i++) begin
				case (kind)
					0: begin
						c[i] = $urandom_range(7) - 4;
					end
					1: begin
						c[i] = (i == 0) ? $urandom : 32'h0;
					end
					2: begin
						c[i] = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					end
					3: begin
						c[i] = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
					end
					4: begin
						c[i] = $urandom_range(1) ? 32'h7FFF_FFFF : $urandom_range(3);
					end
					default: begin
						c[i] = $urandom;
					end
				endcase
			end
			if (kind == 1 && $urandom_range(2) != 0)
				send_vector(c[1], c[0], c[2]);
			else
				send_vector(c[0], c[1], c[2]);
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_vectors();
		test_random_vectors(160);
		send_idle_pct = 53;
		test_random_vectors(160);
		send_idle_pct = 0;
		recv_stall_pct = 53;
		test_random_vectors(160);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		test_random_vectors(170);

		if (!failed)
			$display("PASS vector3_normalize");
		else
			$display("FAIL vector3_normalize");
		$finish;
	end

endmodule
